>>> src/pli_pkg.sv
// Shared types, codes and helpers for the piecewise linear interpolator.
// No dependencies; every other file in src imports this package.
package pli_pkg;

  // Default table depth; the top level hands its own value down.
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Operation codes carried in item_t.op; the fourth code is ignored.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Status codes carried in result_t.status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One breakpoint, both coordinates signed Q16.16
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  // Input item
  typedef struct packed {
    logic        [1:0]  op;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
  } item_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] y_out;
    logic        [1:0]  status;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_Q_FIRST,
    S_Q_WALK,
    S_Q_DIFF,
    S_Q_DIV,
    S_RESULT
  } state_t;

  // True when point (ax, ay) orders strictly after (bx, by): by x, then y.
  function automatic logic sorts_after(logic signed [31:0] ax, logic signed [31:0] ay,
                                       logic signed [31:0] bx, logic signed [31:0] by);
    logic res;
    if (ax != bx) begin
      res = (ax > bx);
    end else begin
      res = (ay > by);
    end
    return res;
  endfunction

endpackage

>>> src/pli_table.sv
// Breakpoint memory: one write port, one read port, registered read data.
// Depends on pli_pkg for point_t. Contents are undefined until written.
module pli_table #(
  parameter int unsigned DEPTH  = pli_pkg::MAX_POINTS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  pli_pkg::point_t     wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output pli_pkg::point_t     rd_data
);
  import pli_pkg::*;

  point_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/pli_muldiv.sv
// Computes floor(dx * mag / span) for one segment: a registered 32x32
// multiply, then a restoring divide that retires one quotient bit a cycle.
// Depends on pli_pkg. The caller guarantees dx < span, so the quotient fits.
module pli_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dx,
  input  logic [31:0] mag,
  input  logic [31:0] span,
  output logic        done,
  output logic [31:0] quotient
);
  import pli_pkg::*;

  logic        busy;
  logic        mul_phase;
  logic [4:0]  step;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] divisor;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [63:0] product;
  logic [32:0] trial;
  logic [32:0] trial_sub;
  logic        take;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign product   = 64'(op_a) * 64'(op_b);
  assign trial     = {rem, quo[31]};
  assign trial_sub = trial - {1'b0, divisor};
  assign take      = (trial >= {1'b0, divisor});
  assign quotient  = quo;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mul_phase <= 1'b0;
      step      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        mul_phase <= 1'b1;
      end else if (busy && mul_phase) begin
        mul_phase <= 1'b0;
        step      <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      op_a    <= dx;
      op_b    <= mag;
      divisor <= span;
    end else if (busy && mul_phase) begin
      // high half is below the divisor, so it seeds the remainder
      rem <= product[63:32];
      quo <= product[31:0];
    end else if (busy) begin
      rem <= take ? trial_sub[31:0] : trial[31:0];
      quo <= {quo[30:0], take};
    end
  end

endmodule

>>> src/piecewise_linear_interpolator_core.sv
// Channel | Signals                            | Payload
// --------+------------------------------------+-------------------------------
// item    | item_valid, item_ready, item       | pli_pkg::item_t (op, x_in, y_in)
// result  | result_valid, result_ready, result | pli_pkg::result_t (y_out, status)
//
// One item at a time. Clear, unused op, full insert, insert into an empty
// table and empty query go straight to the result.
// Insert: a memory read/write loop shifts each later breakpoint up one entry.
// Query: walks the segments from the first breakpoint; a segment hit starts
// the divider for the multiply and the bit-serial divide, while a query
// past the last x skips the divide.
// Reset empties the table at once; memory contents need no clearing.
// A result waiting on result_ready holds back the next item only at its end.
// Depends on pli_pkg, pli_table and pli_muldiv.
module piecewise_linear_interpolator_core #(
  parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  pli_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output pli_pkg::result_t  result
);
  import pli_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    point_count;
  logic [ADDR_W-1:0]   pos;
  logic [ADDR_W-1:0]   idx;
  item_t               pend;
  result_t             res;
  point_t              prev;
  point_t              cur;
  logic signed [31:0]  xq;
  logic                neg;

  // memory and divider hookup
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  point_t              wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  point_t              rd_data;
  logic                div_start;
  logic                div_done;
  logic [31:0]         quo;

  // decode
  logic                accept;
  logic                out_free;
  logic                full;
  logic                empty;
  logic                shift;
  logic                hit;
  logic                last;
  logic [32:0]         dx_full;
  logic [32:0]         span_full;
  logic [32:0]         dy;
  logic [32:0]         dy_neg;
  logic [31:0]         mag;
  logic signed [33:0]  y0_ext;
  logic signed [33:0]  q_ext;
  logic signed [33:0]  sum;
  logic signed [31:0]  sum_sat;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign full       = (point_count == CNT_W'(MAX_POINTS));
  assign empty      = (point_count == '0);
  assign shift      = sorts_after(rd_data.x, rd_data.y, pend.x_in, pend.y_in);
  assign hit        = (xq >= prev.x) && (xq < rd_data.x);
  assign last       = (CNT_W'(idx) == point_count - CNT_W'(1));

  // Segment arithmetic: differences feed the divider, sum forms the answer
  assign dx_full   = {xq[31], xq} - {prev.x[31], prev.x};
  assign span_full = {cur.x[31], cur.x} - {prev.x[31], prev.x};
  assign dy        = {cur.y[31], cur.y} - {prev.y[31], prev.y};
  assign dy_neg    = -dy;
  assign mag       = dy[32] ? dy_neg[31:0] : dy[31:0];
  assign y0_ext    = {{2{prev.y[31]}}, prev.y};
  assign q_ext     = {2'b00, quo};
  assign sum       = neg ? (y0_ext - q_ext) : (y0_ext + q_ext);

  // Saturate to 32 bits signed
  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sum_sat = sum[31:0];
    end else if (sum[33]) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = 32'sh7FFF_FFFF;
    end
  end

  pli_table #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pli_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dx       (dx_full[31:0]),
    .mag      (mag),
    .span     (span_full[31:0]),
    .done     (div_done),
    .quotient (quo)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (item.op == OP_INSERT) begin
            state_next = (full || empty) ? S_RESULT : S_INS_CMP;
          end else if (item.op == OP_QUERY && !empty) begin
            state_next = S_Q_FIRST;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_INS_CMP: begin
        if (!shift) begin
          state_next = S_RESULT;
        end else if (pos == ADDR_W'(1)) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: state_next = S_RESULT;
      S_Q_FIRST: begin
        state_next = (point_count == CNT_W'(1)) ? S_RESULT : S_Q_WALK;
      end
      S_Q_WALK: begin
        if (hit) begin
          state_next = S_Q_DIFF;
        end else if (last) begin
          state_next = S_RESULT;
        end
      end
      S_Q_DIFF: state_next = S_Q_DIV;
      S_Q_DIV: begin
        if (div_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory and divider control. A shift reads pos-2 while writing pos,
  // so the two ports never touch the same entry in one cycle.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && item.op == OP_INSERT && !full) begin
          if (empty) begin
            wr_en   = 1'b1;
            wr_data = '{x: item.x_in, y: item.y_in};
          end else begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(point_count - CNT_W'(1));
          end
        end else if (accept && item.op == OP_QUERY && !empty) begin
          rd_en = 1'b1;
        end
      end
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        if (shift) begin
          wr_data = rd_data;
          if (pos != ADDR_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = pos - ADDR_W'(2);
          end
        end else begin
          wr_data = '{x: pend.x_in, y: pend.y_in};
        end
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = '{x: pend.x_in, y: pend.y_in};
      end
      S_Q_FIRST: begin
        if (point_count != CNT_W'(1)) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(1);
        end
      end
      S_Q_WALK: begin
        if (!hit && !last) begin
          rd_en   = 1'b1;
          rd_addr = idx + ADDR_W'(1);
        end
      end
      S_Q_DIFF: div_start = 1'b1;
      S_Q_DIV, S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESULT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      // table fill count
      if (state == S_IDLE && accept && item.op == OP_CLEAR) begin
        point_count <= '0;
      end else if (state == S_IDLE && accept && item.op == OP_INSERT && empty) begin
        point_count <= CNT_W'(1);
      end else if ((state == S_INS_CMP && !shift) || state == S_INS_PUT) begin
        point_count <= point_count + CNT_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pend       <= item;
          pos        <= ADDR_W'(point_count);
          res.y_out  <= '0;
          res.status <= ST_OK;
          if (item.op == OP_INSERT && full) begin
            res.status <= ST_FULL;
          end else if (item.op == OP_QUERY && empty) begin
            res.status <= ST_EMPTY;
          end
        end
      end
      S_INS_CMP: begin
        if (shift) begin
          pos <= pos - ADDR_W'(1);
        end
      end
      S_Q_FIRST: begin
        // clamp below the first breakpoint
        xq   <= (pend.x_in < rd_data.x) ? rd_data.x : pend.x_in;
        prev <= rd_data;
        idx  <= ADDR_W'(1);
        if (point_count == CNT_W'(1)) begin
          res.y_out <= rd_data.y;
        end
      end
      S_Q_WALK: begin
        if (hit) begin
          cur <= rd_data;
        end else if (last) begin
          res.y_out <= rd_data.y;
        end else begin
          prev <= rd_data;
          idx  <= idx + ADDR_W'(1);
        end
      end
      S_Q_DIFF: neg <= dy[32];
      S_Q_DIV: begin
        if (div_done) begin
          res.y_out <= sum_sat;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          result <= res;
        end
      end
      S_INS_PUT: begin
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("breakpoint count beyond table depth");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && item.op == OP_CLEAR) |=> (point_count == '0))
    else $error("clear did not empty the table");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && item.op == OP_INSERT && full) |=> (point_count == $past(point_count)))
    else $error("dropped insert changed the table");

endmodule
